@@ rtl/gglt_pkg.sv @@
// shared types and constants for the gps gate crossing lap timer
package gglt_pkg;

	localparam int COORD_W    = 24;
	localparam int TIME_W     = 32;
	localparam int MOVE_W     = 40;
	localparam int FRAC_W     = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int NUM_PROD   = 14;
	localparam int STEP_W     = $clog2(NUM_PROD);
	localparam int NUM_RES    = NUM_PROD / 2;
	localparam int RES_IDX_W  = STEP_W - 1;
	localparam int DIV_W      = $clog2(FRAC_W);
	localparam int CFG_DW     = 64;
	localparam int NUM_REGS   = 5;
	localparam int ADDR_LSB   = 3;
	localparam int REG_ADDR_W = $clog2(NUM_REGS * 8);
	localparam int REG_IDX_W  = REG_ADDR_W - ADDR_LSB;

	localparam logic [REG_IDX_W-1:0] REG_GATE_LEFT_LAT  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_GATE_LEFT_LON  = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_GATE_RIGHT_LAT = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_GATE_RIGHT_LON = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_MIN_MOVE_SQ    = REG_IDX_W'(4);

	localparam logic [RES_IDX_W-1:0] RES_SQ  = RES_IDX_W'(0);
	localparam logic [RES_IDX_W-1:0] RES_O1  = RES_IDX_W'(1);
	localparam logic [RES_IDX_W-1:0] RES_O2  = RES_IDX_W'(2);
	localparam logic [RES_IDX_W-1:0] RES_O3  = RES_IDX_W'(3);
	localparam logic [RES_IDX_W-1:0] RES_O4  = RES_IDX_W'(4);
	localparam logic [RES_IDX_W-1:0] RES_DEN = RES_IDX_W'(5);
	localparam logic [RES_IDX_W-1:0] RES_NUM = RES_IDX_W'(6);

	typedef struct packed {
		logic [COORD_W-1:0] left_lat;
		logic [COORD_W-1:0] left_lon;
		logic [COORD_W-1:0] right_lat;
		logic [COORD_W-1:0] right_lon;
		logic [MOVE_W-1:0]  min_move_sq;
	} gglt_cfg_t;

	typedef struct packed {
		logic              load_in;
		logic              mul_en;
		logic [STEP_W-1:0] step;
		logic              div_init;
		logic              div_step;
		logic              tmul;
		logic              finish;
	} gglt_cmd_t;

	typedef struct packed {
		logic go_div;
		logic out_free;
	} gglt_sts_t;

endpackage

@@ rtl/gps_gate_crossing_lap_timer_core.sv @@
// steps: products, drain, decide, then divide and time scaling if tested, then result write
// a new fix is accepted only once the previous one is written to the result register
// the 14 products share one 25x25 multiplier, the fraction comes from a 32-step divider
// the result register frees the input side while a word waits to be taken
// reset: asynchronous, clears previous fix, last crossing time and the gate registers
module gps_gate_crossing_lap_timer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gglt_pkg::REG_ADDR_W-1:0]      paddr,
	input  logic [gglt_pkg::CFG_DW-1:0]          pwdata,
	output logic [gglt_pkg::CFG_DW-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [gglt_pkg::COORD_W-1:0]         lat_offset,
	input  logic [gglt_pkg::COORD_W-1:0]         lon_offset,
	input  logic [gglt_pkg::TIME_W-1:0]          timestamp_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 crossed,
	output logic [gglt_pkg::TIME_W-1:0]          crossing_time_ms,
	output logic [gglt_pkg::TIME_W-1:0]          lap_time_ms
);

	gglt_pkg::gglt_cfg_t cfg;
	gglt_pkg::gglt_cmd_t cmd;
	gglt_pkg::gglt_sts_t sts;

	gglt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gglt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gglt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.sts              (sts),
		.lat_offset       (lat_offset),
		.lon_offset       (lon_offset),
		.timestamp_ms     (timestamp_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.crossed          (crossed),
		.crossing_time_ms (crossing_time_ms),
		.lap_time_ms      (lap_time_ms)
	);

endmodule

@@ rtl/gglt_regs.sv @@
// apb configuration registers for the gate endpoints and movement threshold
module gglt_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gglt_pkg::REG_ADDR_W-1:0]      paddr,
	input  logic [gglt_pkg::CFG_DW-1:0]          pwdata,
	output logic [gglt_pkg::CFG_DW-1:0]          prdata,
	output logic                                 pready,
	output gglt_pkg::gglt_cfg_t                  cfg
);

	gglt_pkg::gglt_cfg_t cfg_q;
	logic [gglt_pkg::REG_IDX_W-1:0] idx;
	logic wr;

	assign idx    = paddr[gglt_pkg::REG_ADDR_W-1:gglt_pkg::ADDR_LSB];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				gglt_pkg::REG_GATE_LEFT_LAT: begin
					cfg_q.left_lat <= pwdata[gglt_pkg::COORD_W-1:0];
				end
				gglt_pkg::REG_GATE_LEFT_LON: begin
					cfg_q.left_lon <= pwdata[gglt_pkg::COORD_W-1:0];
				end
				gglt_pkg::REG_GATE_RIGHT_LAT: begin
					cfg_q.right_lat <= pwdata[gglt_pkg::COORD_W-1:0];
				end
				gglt_pkg::REG_GATE_RIGHT_LON: begin
					cfg_q.right_lon <= pwdata[gglt_pkg::COORD_W-1:0];
				end
				gglt_pkg::REG_MIN_MOVE_SQ: begin
					cfg_q.min_move_sq <= pwdata[gglt_pkg::MOVE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			gglt_pkg::REG_GATE_LEFT_LAT:  prdata = gglt_pkg::CFG_DW'(cfg_q.left_lat);
			gglt_pkg::REG_GATE_LEFT_LON:  prdata = gglt_pkg::CFG_DW'(cfg_q.left_lon);
			gglt_pkg::REG_GATE_RIGHT_LAT: prdata = gglt_pkg::CFG_DW'(cfg_q.right_lat);
			gglt_pkg::REG_GATE_RIGHT_LON: prdata = gglt_pkg::CFG_DW'(cfg_q.right_lon);
			gglt_pkg::REG_MIN_MOVE_SQ:    prdata = gglt_pkg::CFG_DW'(cfg_q.min_move_sq);
			default:                      prdata = '0;
		endcase
	end

endmodule

@@ rtl/gglt_ctrl.sv @@
// sequencing state machine for products, divide, time scaling and result write
module gglt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gglt_pkg::gglt_sts_t sts,
	output gglt_pkg::gglt_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_TMUL   = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q;
	logic [gglt_pkg::STEP_W-1:0] step_q;
	logic [gglt_pkg::DIV_W-1:0] div_cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load_in  = in_valid & in_ready;
		cmd.mul_en   = (state_q == S_MUL);
		cmd.step     = step_q;
		cmd.div_init = (state_q == S_DECIDE);
		cmd.div_step = (state_q == S_DIV);
		cmd.tmul     = (state_q == S_TMUL);
		cmd.finish   = (state_q == S_FIN) & sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
						step_q  <= '0;
					end
				end
				S_MUL: begin
					if (step_q == gglt_pkg::STEP_W'(gglt_pkg::NUM_PROD - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					div_cnt_q <= '0;
					state_q   <= sts.go_div ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_cnt_q == gglt_pkg::DIV_W'(gglt_pkg::FRAC_W - 1)) begin
						state_q <= S_TMUL;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				S_TMUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/gglt_dp.sv @@
// datapath: shared multiplier, cross product results, divider, time scaling
module gglt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gglt_pkg::gglt_cfg_t                 cfg,
	input  gglt_pkg::gglt_cmd_t                 cmd,
	output gglt_pkg::gglt_sts_t                 sts,
	input  logic [gglt_pkg::COORD_W-1:0]        lat_offset,
	input  logic [gglt_pkg::COORD_W-1:0]        lon_offset,
	input  logic [gglt_pkg::TIME_W-1:0]         timestamp_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                crossed,
	output logic [gglt_pkg::TIME_W-1:0]         crossing_time_ms,
	output logic [gglt_pkg::TIME_W-1:0]         lap_time_ms
);

	localparam int CW = gglt_pkg::COORD_W;
	localparam int DW = gglt_pkg::DIFF_W;
	localparam int PW = gglt_pkg::PROD_W;
	localparam int AW = gglt_pkg::ACC_W;
	localparam int TW = gglt_pkg::TIME_W;
	localparam int FW = gglt_pkg::FRAC_W;
	localparam int SW = gglt_pkg::STEP_W;

	localparam logic [1:0] OR_COL = 2'd0;
	localparam logic [1:0] OR_POS = 2'd1;
	localparam logic [1:0] OR_NEG = 2'd2;

	function automatic logic signed [DW-1:0] sdiff(input logic [CW-1:0] a,
			input logic [CW-1:0] b);
		sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic [1:0] ocode(input logic signed [AW-1:0] v);
		if (v == '0) begin
			ocode = OR_COL;
		end else if (v[AW-1]) begin
			ocode = OR_NEG;
		end else begin
			ocode = OR_POS;
		end
	endfunction

	function automatic logic between(input logic [CW-1:0] a, input logic [CW-1:0] v,
			input logic [CW-1:0] b);
		logic [CW-1:0] lo;
		logic [CW-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		between = (v >= lo) && (v <= hi);
	endfunction

	// fix state
	logic [CW-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [TW-1:0] prev_time_q, now_q, last_cross_q;

	// product pipeline
	logic signed [DW-1:0] op_a, op_b;
	logic signed [PW-1:0] prod_s1;
	logic [SW-1:0] step_s1;
	logic vld_s1;
	logic signed [AW-1:0] prod_ext, acc_q, acc_next;
	logic signed [AW-1:0] res_q [gglt_pkg::NUM_RES];

	// decision and divide
	logic [1:0] o1, o2, o3, o4;
	logic move_ok, meet, den_nz, go_div;
	logic signed [AW-1:0] num_v, den_v;
	logic [AW-1:0] abs_num, abs_den, abs_den_q, rem_q, rem_sh;
	logic [FW:0] q_q;
	logic div_run_q, hit_q;

	// time scaling and result
	logic [TW-1:0] dt, off_q, ctime, lap;
	logic [TW+FW-1:0] tprod;
	logic out_valid_q, crossed_q;
	logic [TW-1:0] ctime_q, lap_q;

	logic [CW-1:0] x3, y3, x4, y4;

	assign x3 = cfg.left_lon;
	assign y3 = cfg.left_lat;
	assign x4 = cfg.right_lon;
	assign y4 = cfg.right_lat;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.step)
			SW'(0):  begin op_a = sdiff(x2_q, x1_q); op_b = sdiff(x2_q, x1_q); end
			SW'(1):  begin op_a = sdiff(y2_q, y1_q); op_b = sdiff(y2_q, y1_q); end
			SW'(2):  begin op_a = sdiff(x2_q, x1_q); op_b = sdiff(y3, y2_q);   end
			SW'(3):  begin op_a = sdiff(y2_q, y1_q); op_b = sdiff(x3, x2_q);   end
			SW'(4):  begin op_a = sdiff(x2_q, x1_q); op_b = sdiff(y4, y2_q);   end
			SW'(5):  begin op_a = sdiff(y2_q, y1_q); op_b = sdiff(x4, x2_q);   end
			SW'(6):  begin op_a = sdiff(x4, x3);     op_b = sdiff(y1_q, y4);   end
			SW'(7):  begin op_a = sdiff(y4, y3);     op_b = sdiff(x1_q, x4);   end
			SW'(8):  begin op_a = sdiff(x4, x3);     op_b = sdiff(y2_q, y4);   end
			SW'(9):  begin op_a = sdiff(y4, y3);     op_b = sdiff(x2_q, x4);   end
			SW'(10): begin op_a = sdiff(x1_q, x2_q); op_b = sdiff(y3, y4);     end
			SW'(11): begin op_a = sdiff(y1_q, y2_q); op_b = sdiff(x3, x4);     end
			SW'(12): begin op_a = sdiff(x1_q, x3);   op_b = sdiff(y3, y4);     end
			SW'(13): begin op_a = sdiff(y1_q, y3);   op_b = sdiff(x3, x4);     end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	// even step loads, odd step closes the pair; squared distance adds, cross products subtract
	assign prod_ext = $signed({{(AW - PW){prod_s1[PW-1]}}, prod_s1});
	always_comb begin
		if (!step_s1[0]) begin
			acc_next = prod_ext;
		end else if (step_s1[SW-1:1] == gglt_pkg::RES_SQ) begin
			acc_next = acc_q + prod_ext;
		end else begin
			acc_next = acc_q - prod_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= op_a * op_b;
			step_s1 <= cmd.step;
		end
		if (vld_s1) begin
			acc_q <= acc_next;
			if (step_s1[0]) begin
				res_q[step_s1[SW-1:1]] <= acc_next;
			end
		end
	end

	assign o1 = ocode(res_q[gglt_pkg::RES_O1]);
	assign o2 = ocode(res_q[gglt_pkg::RES_O2]);
	assign o3 = ocode(res_q[gglt_pkg::RES_O3]);
	assign o4 = ocode(res_q[gglt_pkg::RES_O4]);

	assign move_ok = res_q[gglt_pkg::RES_SQ] >
		$signed({{(AW - gglt_pkg::MOVE_W){1'b0}}, cfg.min_move_sq});

	assign meet = ((o1 != o2) && (o3 != o4))
		|| ((o1 == OR_COL) && between(x1_q, x3, x2_q) && between(y1_q, y3, y2_q))
		|| ((o2 == OR_COL) && between(x1_q, x4, x2_q) && between(y1_q, y4, y2_q))
		|| ((o3 == OR_COL) && between(x3, x1_q, x4) && between(y3, y1_q, y4))
		|| ((o4 == OR_COL) && between(x3, x2_q, x4) && between(y3, y2_q, y4));

	assign num_v   = res_q[gglt_pkg::RES_NUM];
	assign den_v   = res_q[gglt_pkg::RES_DEN];
	assign den_nz  = (den_v != '0);
	assign go_div  = move_ok & meet & den_nz;
	assign abs_num = num_v[AW-1] ? (~num_v + AW'(1)) : num_v;
	assign abs_den = den_v[AW-1] ? (~den_v + AW'(1)) : den_v;
	assign rem_sh  = {rem_q[AW-2:0], 1'b0};

	assign dt    = now_q - prev_time_q;
	assign tprod = dt * q_q[FW-1:0];
	assign ctime = hit_q ? (prev_time_q + off_q) : '0;
	assign lap   = hit_q ? (ctime - last_cross_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			div_run_q <= 1'b0;
		end else if (cmd.div_init) begin
			hit_q <= go_div;
			div_run_q <= (num_v != '0) && (num_v[AW-1] == den_v[AW-1])
				&& (abs_num < abs_den);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			abs_den_q <= abs_den;
			rem_q     <= abs_num;
			if ((num_v == '0) || (num_v[AW-1] != den_v[AW-1])) begin
				q_q <= '0;
			end else if (abs_num >= abs_den) begin
				q_q <= {1'b1, {FW{1'b0}}};
			end else begin
				q_q <= '0;
			end
		end else if (cmd.div_step && div_run_q) begin
			if (rem_sh >= abs_den_q) begin
				rem_q <= rem_sh - abs_den_q;
				q_q   <= {q_q[FW-1:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[FW-1:0], 1'b0};
			end
		end
		if (cmd.tmul) begin
			off_q <= q_q[FW] ? dt : tprod[TW+FW-1:FW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q         <= '0;
			y1_q         <= '0;
			prev_time_q  <= '0;
			last_cross_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.finish) begin
				x1_q        <= x2_q;
				y1_q        <= y2_q;
				prev_time_q <= now_q;
				if (hit_q) begin
					last_cross_q <= ctime;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x2_q  <= lon_offset;
			y2_q  <= lat_offset;
			now_q <= timestamp_ms;
		end
		if (cmd.finish) begin
			crossed_q <= hit_q;
			ctime_q   <= ctime;
			lap_q     <= lap;
		end
	end

	assign sts.go_div   = go_div;
	assign sts.out_free = ~out_valid_q | out_ready;

	assign out_valid        = out_valid_q;
	assign crossed          = crossed_q;
	assign crossing_time_ms = ctime_q;
	assign lap_time_ms      = lap_q;

endmodule

@@ rtl/gglt_chk.sv @@
// port-level checks for the lap timer core and their bind
module gglt_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic                                 crossed,
	input logic [gglt_pkg::TIME_W-1:0]          crossing_time_ms,
	input logic [gglt_pkg::TIME_W-1:0]          lap_time_ms
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(crossed)
			&& $stable(crossing_time_ms) && $stable(lap_time_ms))
		else $error("result word changed while stalled");

	// no crossing means zero times
	a_no_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !crossed |-> crossing_time_ms == '0 && lap_time_ms == '0)
		else $error("times nonzero without crossing");

	// one fix at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken while a fix is in work");

endmodule

bind gps_gate_crossing_lap_timer_core gglt_chk u_chk (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the gps gate crossing lap timer core: directed fixes, then random fixes
module testbench;
	import gglt_pkg::*;

	typedef struct packed {
		logic              crossed;
		logic [TIME_W-1:0] ctime;
		logic [TIME_W-1:0] lap;
	} lap_word_t;

	typedef struct {
		int                 cfg_sel;
		logic [COORD_W-1:0] lat;
		logic [COORD_W-1:0] lon;
		logic [TIME_W-1:0]  ts;
		bit                 typed;
		lap_word_t          word;
	} fix_row_t;

	localparam int     NO_CFG      = -1;
	localparam int     N_ROWS      = 18;
	localparam int     N_GATES     = 5;
	localparam int     N_PHASES    = 6;
	localparam int     PHASE_FIXES = 105;
	localparam int     SETTLE      = 60;
	localparam longint COORD_MAX   = (64'd1 << COORD_W) - 1;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [REG_ADDR_W-1:0] paddr;
	logic [CFG_DW-1:0]     pwdata;
	logic [CFG_DW-1:0]     prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	logic [COORD_W-1:0]    lat_offset;
	logic [COORD_W-1:0]    lon_offset;
	logic [TIME_W-1:0]     timestamp_ms;
	logic                  out_valid;
	logic                  out_ready;
	logic                  crossed;
	logic [TIME_W-1:0]     crossing_time_ms;
	logic [TIME_W-1:0]     lap_time_ms;

	gglt_cfg_t          gate_m;
	logic [COORD_W-1:0] prev_lat_m;
	logic [COORD_W-1:0] prev_lon_m;
	logic [TIME_W-1:0]  prev_time_m;
	logic [TIME_W-1:0]  last_cross_m;
	lap_word_t          lap_q[$];
	lap_word_t          pred_w;
	lap_word_t          head_w;
	bit                 row_typed;
	lap_word_t          row_word;
	bit                 idle_on;
	int                 rdy_hold;
	int                 n_fix;
	int                 n_cross;
	int                 n_cfg;
	int                 n_err;
	logic [TIME_W-1:0]  cur_ts;
	gglt_cfg_t          gate_tab[N_GATES];
	fix_row_t           fix_tab[N_ROWS];

	gps_gate_crossing_lap_timer_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.lat_offset       (lat_offset),
		.lon_offset       (lon_offset),
		.timestamp_ms     (timestamp_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.crossed          (crossed),
		.crossing_time_ms (crossing_time_ms),
		.lap_time_ms      (lap_time_ms)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int orient_sign(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint v;
		v = (qx - px) * (ry - qy) - (qy - py) * (rx - qx);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic bit on_segment(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		return qx >= ((px < rx) ? px : rx) && qx <= ((px < rx) ? rx : px)
			&& qy >= ((py < ry) ? py : ry) && qy <= ((py < ry) ? ry : py);
	endfunction

	// lon is x, lat is y
	function automatic lap_word_t predict_fix(logic [COORD_W-1:0] lat, logic [COORD_W-1:0] lon,
			logic [TIME_W-1:0] ts);
		longint      x1, y1, x2, y2, x3, y3, x4, y4;
		longint      sq, den, num, an, ad;
		int          o1, o2, o3, o4;
		bit          meet;
		logic [95:0] quo;
		logic [63:0] q, off;
		logic [31:0] dt;
		lap_word_t   w;
		x1 = prev_lon_m;
		y1 = prev_lat_m;
		x2 = lon;
		y2 = lat;
		x3 = gate_m.left_lon;
		y3 = gate_m.left_lat;
		x4 = gate_m.right_lon;
		y4 = gate_m.right_lat;
		w = '0;
		sq = (x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1);
		if (sq > longint'(gate_m.min_move_sq)) begin
			o1 = orient_sign(x1, y1, x2, y2, x3, y3);
			o2 = orient_sign(x1, y1, x2, y2, x4, y4);
			o3 = orient_sign(x3, y3, x4, y4, x1, y1);
			o4 = orient_sign(x3, y3, x4, y4, x2, y2);
			meet = (o1 != o2 && o3 != o4)
				|| (o1 == 0 && on_segment(x1, y1, x3, y3, x2, y2))
				|| (o2 == 0 && on_segment(x1, y1, x4, y4, x2, y2))
				|| (o3 == 0 && on_segment(x3, y3, x1, y1, x4, y4))
				|| (o4 == 0 && on_segment(x3, y3, x2, y2, x4, y4));
			den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
			if (meet && den != 0) begin
				num = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
				an = (num < 0) ? -num : num;
				ad = (den < 0) ? -den : den;
				if (num == 0 || (num < 0) != (den < 0))
					q = '0;
				else if (an >= ad)
					q = 64'd1 << 32;
				else begin
					quo = (96'(an) << 32) / 96'(ad);
					q = quo[63:0];
				end
				dt = ts - prev_time_m;
				off = (64'(dt) * q) >> 32;
				w.crossed = 1'b1;
				w.ctime = prev_time_m + off[31:0];
				w.lap = w.ctime - last_cross_m;
				last_cross_m = w.ctime;
			end
		end
		prev_lat_m = lat;
		prev_lon_m = lon;
		prev_time_m = ts;
		return w;
	endfunction

	function automatic longint clamp_coord(longint v);
		return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	function automatic gglt_cfg_t random_gate(longint span);
		gglt_cfg_t c;
		longint    base_lat, base_lon;
		base_lat = $urandom_range(COORD_MAX - 2 * span);
		base_lon = $urandom_range(COORD_MAX - 2 * span);
		c.left_lat = COORD_W'(base_lat + $urandom_range(2 * span));
		c.left_lon = COORD_W'(base_lon + $urandom_range(2 * span));
		c.right_lat = COORD_W'(base_lat + $urandom_range(2 * span));
		c.right_lon = COORD_W'(base_lon + $urandom_range(2 * span));
		c.min_move_sq = ($urandom_range(0, 3) == 0) ? '0
			: MOVE_W'((span * span) >> $urandom_range(2, 8));
		return c;
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, ADDR_LSB'(0)};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GATE_LEFT_LAT:  gate_m.left_lat = val[COORD_W-1:0];
			REG_GATE_LEFT_LON:  gate_m.left_lon = val[COORD_W-1:0];
			REG_GATE_RIGHT_LAT: gate_m.right_lat = val[COORD_W-1:0];
			REG_GATE_RIGHT_LON: gate_m.right_lon = val[COORD_W-1:0];
			REG_MIN_MOVE_SQ:    gate_m.min_move_sq = val[MOVE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_gate(gglt_cfg_t c);
		write_reg(REG_GATE_LEFT_LAT, CFG_DW'(c.left_lat));
		write_reg(REG_GATE_LEFT_LON, CFG_DW'(c.left_lon));
		write_reg(REG_GATE_RIGHT_LAT, CFG_DW'(c.right_lat));
		write_reg(REG_GATE_RIGHT_LON, CFG_DW'(c.right_lon));
		write_reg(REG_MIN_MOVE_SQ, CFG_DW'(c.min_move_sq));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_cfg++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (lap_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_fix(logic [COORD_W-1:0] lat, logic [COORD_W-1:0] lon,
			logic [TIME_W-1:0] ts, bit typed, lap_word_t word);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		lat_offset <= lat;
		lon_offset <= lon;
		timestamp_ms <= ts;
		row_typed <= typed;
		row_word <= word;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		cur_ts = ts;
	endtask

	task automatic random_fixes(gglt_cfg_t c, int count);
		longint             span, lat_lo, lat_hi, lon_lo, lon_hi;
		logic [COORD_W-1:0] lat, lon;
		logic [TIME_W-1:0]  ts;
		int                 i, k, r;
		span = (c.left_lat > c.right_lat) ? c.left_lat - c.right_lat : c.right_lat - c.left_lat;
		if (c.left_lon > c.right_lon && c.left_lon - c.right_lon > span)
			span = c.left_lon - c.right_lon;
		if (c.right_lon > c.left_lon && c.right_lon - c.left_lon > span)
			span = c.right_lon - c.left_lon;
		if (span < 8)
			span = 8;
		lat_lo = clamp_coord(((c.left_lat < c.right_lat) ? c.left_lat : c.right_lat) - span);
		lat_hi = clamp_coord(((c.left_lat < c.right_lat) ? c.right_lat : c.left_lat) + span);
		lon_lo = clamp_coord(((c.left_lon < c.right_lon) ? c.left_lon : c.right_lon) - span);
		lon_hi = clamp_coord(((c.left_lon < c.right_lon) ? c.right_lon : c.left_lon) + span);
		for (i = 0; i < count; i++) begin
			k = $urandom_range(0, 9);
			if (k <= 6) begin
				lat = COORD_W'($urandom_range(lat_hi, lat_lo));
				lon = COORD_W'($urandom_range(lon_hi, lon_lo));
			end else if (k == 7) begin
				lat = COORD_W'($urandom);
				lon = COORD_W'($urandom);
			end else if (k == 8) begin
				lat = $urandom_range(0, 1) ? c.left_lat : c.right_lat;
				lon = $urandom_range(0, 1) ? c.left_lon : c.right_lon;
			end else begin
				lat = COORD_W'((longint'(c.left_lat) + c.right_lat) / 2);
				lon = COORD_W'((longint'(c.left_lon) + c.right_lon) / 2);
			end
			r = $urandom_range(0, 19);
			if (r == 0)
				ts = $urandom;
			else if (r == 1)
				ts = cur_ts;
			else
				ts = cur_ts + $urandom_range(1, 400);
			send_fix(lat, lon, ts, 1'b0, '0);
		end
	endtask

	// prediction and checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pred_w = predict_fix(lat_offset, lon_offset, timestamp_ms);
				lap_q.push_back(row_typed ? row_word : pred_w);
				n_fix++;
			end
			if (out_valid && out_ready) begin
				if (lap_q.size() == 0) begin
					$error("word with no fix pending: crossed %0d time %0d lap %0d",
						crossed, crossing_time_ms, lap_time_ms);
					n_err++;
				end else begin
					head_w = lap_q.pop_front();
					if (crossed !== head_w.crossed) begin
						$error("crossed: expected %0d, got %0d", head_w.crossed, crossed);
						n_err++;
					end
					if (crossing_time_ms !== head_w.ctime) begin
						$error("crossing_time_ms: expected %0d, got %0d",
							head_w.ctime, crossing_time_ms);
						n_err++;
					end
					if (lap_time_ms !== head_w.lap) begin
						$error("lap_time_ms: expected %0d, got %0d", head_w.lap, lap_time_ms);
						n_err++;
					end
				end
				if (crossed === 1'b1)
					n_cross++;
			end
		end
	end

	always @(negedge clk) begin
		if (!idle_on)
			out_ready <= 1'b1;
		else if (rdy_hold > 0) begin
			out_ready <= 1'b0;
			rdy_hold <= rdy_hold - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			rdy_hold <= $urandom_range(0, 2);
		end else
			out_ready <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		gglt_cfg_t c;
		int        i, p, n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		lat_offset = '0;
		lon_offset = '0;
		timestamp_ms = '0;
		out_ready = 1'b0;
		row_typed = 1'b0;
		row_word = '0;
		idle_on = 1'b1;
		rdy_hold = 0;
		n_fix = 0;
		n_cross = 0;
		n_cfg = 0;
		n_err = 0;
		cur_ts = '0;
		gate_m = '0;
		prev_lat_m = '0;
		prev_lon_m = '0;
		prev_time_m = '0;
		last_cross_m = '0;

		// vertical gate at lon 500, lat 0 to 1000
		gate_tab[0] = '{24'd0, 24'd500, 24'd1000, 24'd500, 40'd0};
		gate_tab[1] = '{24'd0, 24'd500, 24'd1000, 24'd500, 40'd1000000};
		gate_tab[2] = '{24'd0, 24'd500, 24'd1000, 24'd500, 40'd999999};
		gate_tab[3] = '{24'd0, 24'd500, 24'd1000, 24'd500, 40'hFF_FFFF_FFFF};
		// zero-length gate
		gate_tab[4] = '{24'd100, 24'd100, 24'd100, 24'd100, 40'd0};

		fix_tab = '{
			'{0,      24'd0,        24'd0,        32'd100,        1'b1, '{1'b0, 32'd0, 32'd0}},
			'{NO_CFG, 24'd200,      24'd1000,     32'd1100,       1'b1,
				'{1'b1, 32'd600, 32'd600}},
			'{NO_CFG, 24'd200,      24'd0,        32'd2100,       1'b1,
				'{1'b1, 32'd1600, 32'd1000}},
			'{NO_CFG, 24'd300,      24'd500,      32'd3100,       1'b1,
				'{1'b1, 32'd3100, 32'd1500}},
			'{NO_CFG, 24'd900,      24'd500,      32'd4100,       1'b1, '{1'b0, 32'd0, 32'd0}},
			'{NO_CFG, 24'd900,      24'd600,      32'd5100,       1'b1,
				'{1'b1, 32'd4100, 32'd1000}},
			'{NO_CFG, 24'd2000,     24'd700,      32'd6100,       1'b1, '{1'b0, 32'd0, 32'd0}},
			'{NO_CFG, 24'd2000,     24'd0,        32'd7100,       1'b1, '{1'b0, 32'd0, 32'd0}},
			'{NO_CFG, 24'd0,        24'd1000,     32'd5100,       1'b0, '0},
			'{NO_CFG, 24'hFF_FFFF,  24'hFF_FFFF,  32'hFFFF_FFFF,  1'b1, '{1'b0, 32'd0, 32'd0}},
			'{NO_CFG, 24'd0,        24'd0,        32'd0,          1'b0, '0},
			'{NO_CFG, 24'd500,      24'd0,        32'd1000,       1'b1, '{1'b0, 32'd0, 32'd0}},
			'{1,      24'd500,      24'd1000,     32'd2000,       1'b1, '{1'b0, 32'd0, 32'd0}},
			'{2,      24'd500,      24'd0,        32'd3000,       1'b0, '0},
			'{3,      24'd500,      24'd1000,     32'd4000,       1'b1, '{1'b0, 32'd0, 32'd0}},
			'{NO_CFG, 24'hFF_FFFF,  24'd0,        32'd5000,       1'b0, '0},
			'{4,      24'd200,      24'd200,      32'd6000,       1'b0, '0},
			'{NO_CFG, 24'd0,        24'd0,        32'd7000,       1'b1, '{1'b0, 32'd0, 32'd0}}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < N_ROWS; i++) begin
			if (fix_tab[i].cfg_sel != NO_CFG) begin
				drain();
				load_gate(gate_tab[fix_tab[i].cfg_sel]);
			end
			send_fix(fix_tab[i].lat, fix_tab[i].lon, fix_tab[i].ts, fix_tab[i].typed,
				fix_tab[i].word);
		end

		for (p = 0; p < N_PHASES; p++) begin
			if (p == 0)
				c = '{24'd0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 40'd0};
			else if (p == 1)
				c = '{24'hFF_FFFF, 24'd0, 24'd0, 24'hFF_FFFF, 40'hFF_FFFF_FFFF};
			else
				c = random_gate(64'd1 << $urandom_range(2, 20));
			drain();
			idle_on = (p != N_PHASES - 1);
			load_gate(c);
			random_fixes(c, PHASE_FIXES);
		end

		in_valid <= 1'b0;
		for (n = 0; n < 200000 && lap_q.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (lap_q.size() != 0) begin
			$error("%0d expected words never arrived", lap_q.size());
			n_err++;
		end
		$display("run covered %0d fixes under %0d gate settings, %0d of them crossing the gate",
			n_fix, n_cfg, n_cross);
		if (n_err == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/gglt_pkg.sv
rtl/gglt_regs.sv
rtl/gglt_ctrl.sv
rtl/gglt_dp.sv
rtl/gps_gate_crossing_lap_timer_core.sv
rtl/gglt_chk.sv
test/testbench.sv
